// ===== sv/agu_pkg.sv =====
// Shared types and constants of the AdaGrad weight update block.
// Used by the accumulator, square root, divider and top-level modules.
package agu_pkg;

	localparam int Entries = 4096;
	localparam int SlotW = 12;
	localparam logic [63:0] EpsQ48 = 64'd28147498;
	localparam logic [31:0] RateReset = 32'd838861;

	localparam int SqrtPerStage = 2;
	localparam int SqrtStages = 32 / SqrtPerStage;
	localparam int DivBits = 33;
	localparam int DivPerStage = 3;
	localparam int DivStages = DivBits / DivPerStage;

	typedef struct packed {
		logic        neg;
		logic [31:0] weight;
		logic [31:0] companion;
	} wc_t;

	typedef struct packed {
		wc_t         wc;
		logic [63:0] num;
	} side_t;

endpackage

// ===== sv/agu_accum.sv =====
// Accumulator stages: squared-gradient store with read-modify-write forwarding,
// clearing pass after reset, and the epsilon add. Depends on agu_pkg.
module agu_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_take,
	input  logic [agu_pkg::SlotW-1:0] slot,
	input  logic [31:0]               grad,
	input  logic [31:0]               wgt,
	input  logic [31:0]               comp,
	input  logic [31:0]               rate,
	output logic                      busy,
	output logic                      v_out,
	output logic [63:0]               denom_out,
	output agu_pkg::side_t            side_out
);

	logic [63:0] mem_q [agu_pkg::Entries];
	logic [agu_pkg::SlotW-1:0] clr_q;
	logic clr_busy_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [agu_pkg::SlotW-1:0] slot_s1, slot_s2;
	logic [31:0] grad_s1, wgt_s1, comp_s1, rate_s1;
	logic [63:0] rdata_s1, rdata_s2, sq_s2, acc_s3, denom_s4;
	agu_pkg::side_t side_s2, side_s3, side_s4;

	logic hv1_q, hv2_q;
	logic [agu_pkg::SlotW-1:0] hidx1_q, hidx2_q;
	logic [63:0] hval1_q, hval2_q;

	logic [31:0] mag_g;
	logic [63:0] fwd, acc_new;
	logic [64:0] sum_acc, sum_eps;

	assign busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == agu_pkg::SlotW'(agu_pkg::Entries - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (en && v_s2) begin
			mem_q[slot_s2] <= acc_new;
		end
		if (en) begin
			rdata_s1 <= mem_q[slot];
		end
	end

	assign mag_g = grad_s1[31] ? (~grad_s1 + 32'd1) : grad_s1;

	always_comb begin
		if (hv1_q && hidx1_q == slot_s2) begin
			fwd = hval1_q;
		end else if (hv2_q && hidx2_q == slot_s2) begin
			fwd = hval2_q;
		end else begin
			fwd = rdata_s2;
		end
		sum_acc = {1'b0, fwd} + {1'b0, sq_s2};
		acc_new = sum_acc[64] ? '1 : sum_acc[63:0];
		sum_eps = {1'b0, acc_s3} + {1'b0, agu_pkg::EpsQ48};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			hv1_q <= 1'b0;
			hv2_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			hv1_q <= v_s2;
			hv2_q <= hv1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= slot;
			grad_s1 <= grad;
			wgt_s1 <= wgt;
			comp_s1 <= comp;
			rate_s1 <= rate;
			slot_s2 <= slot_s1;
			rdata_s2 <= rdata_s1;
			sq_s2 <= 64'(mag_g) * 64'(mag_g);
			side_s2.num <= 64'(rate_s1) * 64'(mag_g);
			side_s2.wc.neg <= grad_s1[31];
			side_s2.wc.weight <= wgt_s1;
			side_s2.wc.companion <= comp_s1;
			acc_s3 <= acc_new;
			side_s3 <= side_s2;
			denom_s4 <= sum_eps[64] ? '1 : sum_eps[63:0];
			side_s4 <= side_s3;
			hidx1_q <= slot_s2;
			hval1_q <= acc_new;
			hidx2_q <= hidx1_q;
			hval2_q <= hval1_q;
		end
	end

	assign v_out = v_s4;
	assign denom_out = denom_s4;
	assign side_out = side_s4;

`ifndef SYNTHESIS
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s1 && !v_s2 && !in_take)
		else $error("item in accumulator during clearing pass");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("clearing pass restarted");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_s2 == $past(v_s2) && hv1_q == $past(hv1_q))
		else $error("accumulator stage moved while stalled");
`endif

endmodule

// ===== sv/agu_sqrt.sv =====
// Pipelined integer square root, two result bits per stage, with sideband.
// Depends on agu_pkg.
module agu_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  logic [63:0]    x_in,
	input  agu_pkg::side_t side_in,
	output logic           v_out,
	output logic [31:0]    root_out,
	output agu_pkg::side_t side_out
);

	logic           v_s    [agu_pkg::SqrtStages];
	logic [63:0]    rad_s  [agu_pkg::SqrtStages];
	logic [31:0]    root_s [agu_pkg::SqrtStages];
	logic [32:0]    rem_s  [agu_pkg::SqrtStages];
	agu_pkg::side_t side_s [agu_pkg::SqrtStages];

	logic [63:0] rad_p  [agu_pkg::SqrtStages];
	logic [31:0] root_p [agu_pkg::SqrtStages];
	logic [32:0] rem_p  [agu_pkg::SqrtStages];
	logic [63:0] rad_n  [agu_pkg::SqrtStages];
	logic [31:0] root_n [agu_pkg::SqrtStages];
	logic [32:0] rem_n  [agu_pkg::SqrtStages];

	for (genvar k = 0; k < agu_pkg::SqrtStages; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign rad_p[k] = x_in;
			assign root_p[k] = '0;
			assign rem_p[k] = '0;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_in;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= side_in;
				end
			end
		end else begin : g_next
			assign rad_p[k] = rad_s[k-1];
			assign root_p[k] = root_s[k-1];
			assign rem_p[k] = rem_s[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end

		always_comb begin : p_iter
			logic [63:0] x;
			logic [31:0] r;
			logic [32:0] m;
			logic [34:0] t;
			logic [34:0] tr;
			x = rad_p[k];
			r = root_p[k];
			m = rem_p[k];
			for (int i = 0; i < agu_pkg::SqrtPerStage; i++) begin
				t = {m, x[63:62]};
				tr = {1'b0, r, 2'b01};
				if (t >= tr) begin
					t = t - tr;
					r = {r[30:0], 1'b1};
				end else begin
					r = {r[30:0], 1'b0};
				end
				m = t[32:0];
				x = {x[61:0], 2'b00};
			end
			rad_n[k] = x;
			root_n[k] = r;
			rem_n[k] = m;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_n[k];
				root_s[k] <= root_n[k];
				rem_s[k] <= rem_n[k];
			end
		end
	end

	assign v_out = v_s[agu_pkg::SqrtStages-1];
	assign root_out = root_s[agu_pkg::SqrtStages-1];
	assign side_out = side_s[agu_pkg::SqrtStages-1];

endmodule

// ===== sv/agu_div.sv =====
// Pipelined restoring divider, three quotient bits per stage, with overflow
// flag for quotients of 2^33 and more. Depends on agu_pkg.
module agu_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  logic [63:0]  num_in,
	input  logic [31:0]  d_in,
	input  agu_pkg::wc_t wc_in,
	output logic         v_out,
	output logic         ovf_out,
	output logic [32:0]  q_out,
	output agu_pkg::wc_t wc_out
);

	logic         v_s   [agu_pkg::DivStages];
	logic         ovf_s [agu_pkg::DivStages];
	logic [31:0]  rem_s [agu_pkg::DivStages];
	logic [32:0]  q_s   [agu_pkg::DivStages];
	logic [32:0]  nb_s  [agu_pkg::DivStages];
	logic [31:0]  d_s   [agu_pkg::DivStages];
	agu_pkg::wc_t wc_s  [agu_pkg::DivStages];

	logic [31:0] rem_p [agu_pkg::DivStages];
	logic [32:0] q_p   [agu_pkg::DivStages];
	logic [32:0] nb_p  [agu_pkg::DivStages];
	logic [31:0] d_p   [agu_pkg::DivStages];
	logic [31:0] rem_n [agu_pkg::DivStages];
	logic [32:0] q_n   [agu_pkg::DivStages];
	logic [32:0] nb_n  [agu_pkg::DivStages];

	for (genvar k = 0; k < agu_pkg::DivStages; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign rem_p[k] = {1'b0, num_in[63:33]};
			assign q_p[k] = '0;
			assign nb_p[k] = num_in[32:0];
			assign d_p[k] = d_in;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_in;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					ovf_s[k] <= {1'b0, num_in[63:33]} >= d_in;
					wc_s[k] <= wc_in;
				end
			end
		end else begin : g_next
			assign rem_p[k] = rem_s[k-1];
			assign q_p[k] = q_s[k-1];
			assign nb_p[k] = nb_s[k-1];
			assign d_p[k] = d_s[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					ovf_s[k] <= ovf_s[k-1];
					wc_s[k] <= wc_s[k-1];
				end
			end
		end

		always_comb begin : p_iter
			logic [31:0] r;
			logic [32:0] q;
			logic [32:0] nb;
			logic [32:0] t;
			r = rem_p[k];
			q = q_p[k];
			nb = nb_p[k];
			for (int i = 0; i < agu_pkg::DivPerStage; i++) begin
				t = {r, nb[32]};
				if (t >= {1'b0, d_p[k]}) begin
					t = t - {1'b0, d_p[k]};
					q = {q[31:0], 1'b1};
				end else begin
					q = {q[31:0], 1'b0};
				end
				r = t[31:0];
				nb = {nb[31:0], 1'b0};
			end
			rem_n[k] = r;
			q_n[k] = q;
			nb_n[k] = nb;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n[k];
				q_s[k] <= q_n[k];
				nb_s[k] <= nb_n[k];
				d_s[k] <= d_p[k];
			end
		end
	end

	assign v_out = v_s[agu_pkg::DivStages-1];
	assign ovf_out = ovf_s[agu_pkg::DivStages-1];
	assign q_out = q_s[agu_pkg::DivStages-1];
	assign wc_out = wc_s[agu_pkg::DivStages-1];

endmodule

// ===== sv/adagrad_weight_update.sv =====
// Top level of the AdaGrad weight update block: configuration register, pipeline
// enable, and the saturating step and weight output stage.
// Depends on agu_pkg, agu_accum, agu_sqrt and agu_div.
//
// Usage: a request on the input channel (in_valid, in_stall) carries a parameter
// index, gradient, weight and companion weight. A request on the output channel
// (out_valid, out_stall) returns the new weight, new companion and step.
// The learning rate is written through cfg_valid/cfg_ready/learning_rate; cfg_ready
// is always high. The user makes writes only while the block is idle; the block
// does not enforce this. A request passes from the accepting edge to out_valid
// through 32 register stages: four accumulator stages, sixteen square root stages
// at two root bits each, eleven divider stages at three quotient bits each, and the
// output register. One request is accepted per cycle while in_stall is low;
// repeated indices are forwarded from the last two store writes.
// After reset the block clears its 4096-entry accumulator store, one entry per
// cycle, and holds in_stall high until it is done; the rate resets to 0.05.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises until the waiting result is taken; nothing is lost or repeated.
module adagrad_weight_update (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [agu_pkg::SlotW-1:0] param_index,
	input  logic signed [31:0]        gradient,
	input  logic signed [31:0]        weight,
	input  logic signed [31:0]        companion_weight,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        new_weight,
	output logic signed [31:0]        new_companion,
	output logic signed [31:0]        step_amount,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [31:0]               learning_rate
);

	logic [31:0] rate_q;
	logic en, busy, in_take;
	logic acc_v, sq_v, div_v, ovf;
	logic [63:0] denom;
	logic [31:0] root;
	logic [32:0] quot;
	agu_pkg::side_t acc_side, sq_side;
	agu_pkg::wc_t div_wc;

	logic out_v_q;
	logic [31:0] nw_q, nc_q, step_q;
	logic [31:0] step;
	logic [32:0] dw, dc;

	assign cfg_ready = 1'b1;
	assign en = !out_v_q || !out_stall;
	assign in_stall = !en || busy;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= agu_pkg::RateReset;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= learning_rate;
		end
	end

	agu_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_take   (in_take),
		.slot      (param_index),
		.grad      (gradient),
		.wgt       (weight),
		.comp      (companion_weight),
		.rate      (rate_q),
		.busy      (busy),
		.v_out     (acc_v),
		.denom_out (denom),
		.side_out  (acc_side)
	);

	agu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (acc_v),
		.x_in     (denom),
		.side_in  (acc_side),
		.v_out    (sq_v),
		.root_out (root),
		.side_out (sq_side)
	);

	agu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (sq_v),
		.num_in  (sq_side.num),
		.d_in    (root),
		.wc_in   (sq_side.wc),
		.v_out   (div_v),
		.ovf_out (ovf),
		.q_out   (quot),
		.wc_out  (div_wc)
	);

	always_comb begin
		if (div_wc.neg) begin
			if (ovf || quot > 33'h080000000) begin
				step = 32'h80000000;
			end else begin
				step = ~quot[31:0] + 32'd1;
			end
		end else begin
			if (ovf || quot > 33'h07FFFFFFF) begin
				step = 32'h7FFFFFFF;
			end else begin
				step = quot[31:0];
			end
		end
		dw = {div_wc.weight[31], div_wc.weight} - {step[31], step};
		dc = {div_wc.companion[31], div_wc.companion} - {step[31], step};
	end

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'h80000000 : 32'h7FFFFFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nw_q <= sat33(dw);
			nc_q <= sat33(dc);
			step_q <= step;
		end
	end

	assign out_valid = out_v_q;
	assign new_weight = nw_q;
	assign new_companion = nc_q;
	assign step_amount = step_q;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_stall |-> in_stall)
		else $error("input taken while output is stalled");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_take && !out_v_q)
		else $error("activity during clearing pass");
	a_rate_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(rate_q))
		else $error("learning rate changed without a write");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for adagrad_weight_update: directed table, then random requests
// checked against an in-bench AdaGrad predictor. Depends on agu_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;

	localparam int IdleLimit = 20000;
	localparam int Settle = 40;
	localparam int RandItems = 1500;
	localparam int Phases = 5;

	typedef struct packed {
		logic [agu_pkg::SlotW-1:0] slot;
		logic signed [31:0]        grad;
		logic signed [31:0]        w;
		logic signed [31:0]        c;
	} upd_req_t;

	typedef struct packed {
		logic signed [31:0] nw;
		logic signed [31:0] nc;
		logic signed [31:0] step;
	} upd_res_t;

	typedef struct packed {
		logic        new_rate;
		logic [31:0] rate;
		upd_req_t    req;
		logic        typed;
		upd_res_t    res;
	} dir_row_t;

	localparam int DirRows = 20;
	localparam dir_row_t Directed [DirRows] = '{
		'{1'b1, agu_pkg::RateReset, '{12'd0, 32'sh0, 32'sh7FFFFFFF, 32'sh80000000}, 1'b1,
			'{32'sh7FFFFFFF, 32'sh80000000, 32'sh0}},
		'{1'b0, 32'd0, '{12'd4095, 32'sh0, -32'sd1, 32'sd1}, 1'b1,
			'{-32'sd1, 32'sd1, 32'sh0}},
		'{1'b0, 32'd0, '{12'd1, 32'sh01000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd1, 32'shFF000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd2, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd3, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd5, 32'sh80000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd5, 32'sh80000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd5, 32'sh80000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd5, 32'sh80000000, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd5, 32'sh7FFFFFFF, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd6, 32'sd1, 32'sh80000000, 32'sh7FFFFFFF}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'd7, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'hAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555}, 1'b0, '0},
		'{1'b0, 32'd0, '{12'h555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA}, 1'b0, '0},
		'{1'b1, 32'hFFFFFFFF, '{12'd100, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000},
			1'b1, '{32'sh7FFFFFFF, 32'sh0, 32'sh80000000}},
		'{1'b0, 32'd0, '{12'd101, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0}, 1'b1,
			'{32'sh80000000, 32'sh80000001, 32'sh7FFFFFFF}},
		'{1'b0, 32'd0, '{12'd102, 32'sh00000100, 32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
		'{1'b1, 32'd0, '{12'd103, 32'sh12345678, 32'sh0BADF00D, 32'shCAFEF00D}, 1'b1,
			'{32'sh0BADF00D, 32'shCAFEF00D, 32'sh0}},
		'{1'b0, 32'd0, '{12'd103, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF}, 1'b1,
			'{32'sh80000000, 32'sh7FFFFFFF, 32'sh0}}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [agu_pkg::SlotW-1:0] param_index;
	logic signed [31:0] gradient;
	logic signed [31:0] weight;
	logic signed [31:0] companion_weight;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] new_weight;
	logic signed [31:0] new_companion;
	logic signed [31:0] step_amount;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] learning_rate;

	logic [63:0] sq_sums [agu_pkg::Entries];
	logic [63:0] rate_q24;
	upd_res_t pending_updates [$];
	int mismatches;
	int idle_cycles;
	bit hold_out;
	bit quiet;

	adagrad_weight_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.param_index(param_index),
		.gradient(gradient),
		.weight(weight),
		.companion_weight(companion_weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_weight(new_weight),
		.new_companion(new_companion),
		.step_amount(step_amount),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.learning_rate(learning_rate)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// Updates the accumulator of the slot and returns the new weights and step.
	function automatic upd_res_t adagrad_update(upd_req_t r);
		longint g;
		logic [63:0] mag;
		logic [64:0] sum;
		logic [63:0] acc;
		logic [63:0] q;
		longint step;
		upd_res_t res;
		g = longint'(r.grad);
		mag = (g < 0) ? 64'(-g) : 64'(g);
		sum = {1'b0, sq_sums[r.slot % agu_pkg::Entries]} + {1'b0, mag * mag};
		acc = sum[64] ? '1 : sum[63:0];
		sq_sums[r.slot % agu_pkg::Entries] = acc;
		sum = {1'b0, acc} + {1'b0, agu_pkg::EpsQ48};
		q = (rate_q24 * mag) / isqrt64(sum[64] ? '1 : sum[63:0]);
		if (g < 0)
			step = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
		else
			step = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
		res.step = step[31:0];
		res.nw = clamp32(longint'(r.w) - step);
		res.nc = clamp32(longint'(r.c) - step);
		return res;
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_request(upd_req_t r, bit typed, upd_res_t res);
		bit fire;
		upd_res_t p;
		param_index <= r.slot;
		gradient <= r.grad;
		weight <= r.w;
		companion_weight <= r.c;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			fire = in_valid && !in_stall;
			@(posedge clk);
		end while (!fire);
		p = adagrad_update(r);
		pending_updates.push_back(typed ? res : p);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_rate(logic [31:0] v);
		bit fire;
		cfg_valid <= 1'b1;
		learning_rate <= v;
		do begin
			@(negedge clk);
			fire = cfg_valid && cfg_ready;
			@(posedge clk);
		end while (!fire);
		cfg_valid <= 1'b0;
		rate_q24 = {32'd0, v};
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic upd_req_t random_request(logic [agu_pkg::SlotW-1:0] prev,
			logic [agu_pkg::SlotW-1:0] hot);
		upd_req_t r;
		int k;
		k = $urandom_range(0, 9);
		r.slot = (k < 4) ? hot : (k < 6) ? prev :
			agu_pkg::SlotW'($urandom_range(0, agu_pkg::Entries - 1));
		case ($urandom_range(0, 9))
			0: r.grad = '0;
			1: r.grad = pick_value();
			2, 3: r.grad = $urandom;
			default: r.grad = $signed($urandom_range(0, 2 ** 27 - 1)) - 32'sd67108864;
		endcase
		r.w = pick_value();
		r.c = pick_value();
		return r;
	endfunction

	always @(negedge clk) begin
		upd_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_updates.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				e = pending_updates.pop_front();
				if (new_weight !== e.nw)
					flag_mismatch($sformatf("new_weight %h, want %h", new_weight, e.nw));
				if (new_companion !== e.nc)
					flag_mismatch($sformatf("new_companion %h, want %h", new_companion, e.nc));
				if (step_amount !== e.step)
					flag_mismatch($sformatf("step_amount %h, want %h", step_amount, e.step));
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver side: random stall bursts, plus one long hold on request.
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		upd_req_t r;
		logic [agu_pkg::SlotW-1:0] prev;
		logic [agu_pkg::SlotW-1:0] hot [8];
		logic [31:0] rates [Phases];
		int per_phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		param_index = '0;
		gradient = '0;
		weight = '0;
		companion_weight = '0;
		cfg_valid = 1'b0;
		learning_rate = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_out = 1'b0;
		quiet = 1'b0;
		rate_q24 = {32'd0, agu_pkg::RateReset};
		prev = '0;
		foreach (sq_sums[i])
			sq_sums[i] = '0;
		foreach (hot[i])
			hot[i] = agu_pkg::SlotW'($urandom_range(0, agu_pkg::Entries - 1));
		rates = '{32'hFFFFFFFF, 32'd0, $urandom, 32'd1, agu_pkg::RateReset};
		per_phase = RandItems / Phases;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (Directed[i]) begin
			if (Directed[i].new_rate) begin
				drain();
				write_rate(Directed[i].rate);
			end
			send_request(Directed[i].req, Directed[i].typed, Directed[i].res);
		end

		for (int ph = 0; ph < Phases; ph++) begin
			drain();
			write_rate(rates[ph]);
			quiet = (ph == Phases - 1);
			for (int n = 0; n < per_phase; n++) begin
				if (ph == 1 && n == per_phase / 2)
					hold_out = 1'b1;
				if (ph == 2 && n == per_phase / 2) begin
					in_valid <= 1'b0;
					do
						@(posedge clk);
					while (pending_updates.size() != 0);
				end
				r = random_request(prev, hot[$urandom_range(0, 7)]);
				prev = r.slot;
				send_request(r, 1'b0, '0);
				if (!quiet && $urandom_range(0, 7) == 0)
					pause_sender($urandom_range(1, 17));
			end
		end

		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/agu_pkg.sv
sv/agu_accum.sv
sv/agu_sqrt.sv
sv/agu_div.sv
sv/adagrad_weight_update.sv
verif/testbench.sv
